### sv/mea_pkg.sv
// Shared types and constants for the monomial exponent ALU.
`default_nettype none
package mea_pkg;

  localparam int NumLanes   = 32;
  localparam int LanesWord  = 8;
  localparam int NumWords   = NumLanes / LanesWord;
  localparam int ExpW       = 7;
  localparam int RankW      = 6;
  localparam int DegW       = 12;
  localparam int ValW       = 13;
  localparam int WordDegW   = 10;

  typedef logic [ExpW-1:0] exp_t;
  typedef logic [7:0]      byte_t;
  typedef logic [63:0]     word_t;

  typedef enum logic [3:0] {
    CmdEquals   = 4'd0,
    CmdDivides  = 4'd1,
    CmdDivide   = 4'd2,
    CmdMultiply = 4'd3,
    CmdLcm      = 4'd4,
    CmdGcd      = 4'd5,
    CmdDegree   = 4'd6,
    CmdRevlex   = 4'd7,
    CmdGrevlex  = 4'd8
  } cmd_e;

  typedef struct packed {
    logic [NumLanes-1:0] t_gt_s;
    logic [NumLanes-1:0] t_lt_s;
  } lane_cmp_t;

  typedef struct packed {
    logic               equal;
    logic               t_div_s;
    logic               s_div_t;
    logic               mul_ovf;
    logic [DegW-1:0]    deg_t;
    logic [DegW-1:0]    deg_s;
    logic signed [7:0]  revlex;
  } reduce_t;

endpackage
`default_nettype wire

### sv/monomial_exponent_alu.sv
// Top level of the monomial exponent ALU: input register, lane logic, result register.
`default_nettype none
// A transaction is taken at any clock edge with start_i high; busy_o stays low, so one
// command per cycle is accepted. Its result appears after the input register and the
// result register, and done_o marks it for exactly one cycle; the
// receiver must take it then. Exponents use their low 7 bits, and variables at or above
// min(rank, NUM_VARS) count as zero. Write rank only while no command is in flight.
module monomial_exponent_alu #(
  parameter int NUM_VARS = 32
) (
  input  wire  logic                       clk_i,
  input  wire  logic                       rst_ni,
  input  wire  logic                       start_i,
  output       logic                       busy_o,
  input  wire  logic                       cfg_we_i,
  input  wire  logic [mea_pkg::RankW-1:0]  cfg_wdata_i,
  input  wire  logic [3:0]                 command_i,
  input  wire  logic [63:0]                t_word0_i,
  input  wire  logic [63:0]                t_word1_i,
  input  wire  logic [63:0]                t_word2_i,
  input  wire  logic [63:0]                t_word3_i,
  input  wire  logic [63:0]                s_word0_i,
  input  wire  logic [63:0]                s_word1_i,
  input  wire  logic [63:0]                s_word2_i,
  input  wire  logic [63:0]                s_word3_i,
  output       logic                       done_o,
  output       logic [63:0]                res_word0_o,
  output       logic [63:0]                res_word1_o,
  output       logic [63:0]                res_word2_o,
  output       logic [63:0]                res_word3_o,
  output       logic                       flag_o,
  output       logic                       overflow_o,
  output       logic signed [mea_pkg::ValW-1:0] value_o
);
  import mea_pkg::*;

  localparam logic [RankW-1:0] RankReset = RankW'(NumLanes);
  localparam logic [RankW-1:0] NumVarsW  = RankW'(NUM_VARS);
  localparam logic signed [ValW-1:0] ValPlus  = ValW'(1);
  localparam logic signed [ValW-1:0] ValMinus = -ValW'(1);

  logic [RankW-1:0] rank_q;
  logic [RankW-1:0] active;
  logic             accept;

  word_t t_word [NumWords];
  word_t s_word [NumWords];

  logic                     valid_q;
  logic [3:0]               cmd_q;
  exp_t [NumLanes-1:0]      t_d, t_q, s_d, s_q;

  byte_t [NumLanes-1:0]     diff, sum;
  exp_t  [NumLanes-1:0]     lmax, lmin;
  lane_cmp_t                cmp;
  reduce_t                  red;

  byte_t [NumLanes-1:0]     res_d, res_q;
  logic                     flag_d, flag_q, ovf_d, ovf_q, done_q;
  logic signed [ValW-1:0]   val_d, val_q;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;
  assign active = (rank_q > NumVarsW) ? NumVarsW : rank_q;

  assign t_word[0] = t_word0_i;
  assign t_word[1] = t_word1_i;
  assign t_word[2] = t_word2_i;
  assign t_word[3] = t_word3_i;
  assign s_word[0] = s_word0_i;
  assign s_word[1] = s_word1_i;
  assign s_word[2] = s_word2_i;
  assign s_word[3] = s_word3_i;

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      if (RankW'(i) < active) begin
        t_d[i] = t_word[i/LanesWord][(i%LanesWord)*8 +: ExpW];
        s_d[i] = s_word[i/LanesWord][(i%LanesWord)*8 +: ExpW];
      end else begin
        t_d[i] = '0;
        s_d[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q  <= RankReset;
      valid_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        rank_q <= cfg_wdata_i;
      end
      valid_q <= accept;
      done_q  <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= command_i;
      t_q   <= t_d;
      s_q   <= s_d;
    end
    res_q  <= res_d;
    flag_q <= flag_d;
    ovf_q  <= ovf_d;
    val_q  <= val_d;
  end

  mea_lanes u_lanes (
    .t_i    (t_q),
    .s_i    (s_q),
    .diff_o (diff),
    .sum_o  (sum),
    .max_o  (lmax),
    .min_o  (lmin),
    .cmp_o  (cmp)
  );

  mea_reduce u_reduce (
    .t_i    (t_q),
    .s_i    (s_q),
    .diff_i (diff),
    .sum_i  (sum),
    .cmp_i  (cmp),
    .red_o  (red)
  );

  always_comb begin
    res_d  = '0;
    flag_d = 1'b0;
    ovf_d  = 1'b0;
    val_d  = '0;
    case (cmd_e'(cmd_q))
      CmdEquals:   flag_d = red.equal;
      CmdDivides:  flag_d = red.t_div_s;
      CmdDivide: begin
        flag_d = red.s_div_t;
        if (red.s_div_t) begin
          res_d = diff;
        end
      end
      CmdMultiply: begin
        res_d = sum;
        ovf_d = red.mul_ovf;
      end
      CmdLcm: begin
        for (int i = 0; i < NumLanes; i++) res_d[i] = {1'b0, lmax[i]};
      end
      CmdGcd: begin
        for (int i = 0; i < NumLanes; i++) res_d[i] = {1'b0, lmin[i]};
      end
      CmdDegree:   val_d = signed'({1'b0, red.deg_t});
      CmdRevlex:   val_d = {{(ValW-8){red.revlex[7]}}, red.revlex};
      CmdGrevlex: begin
        if (red.deg_t > red.deg_s) begin
          val_d = ValPlus;
        end else if (red.deg_t < red.deg_s) begin
          val_d = ValMinus;
        end else if (red.revlex < 0) begin
          val_d = ValPlus;
        end else if (red.revlex > 0) begin
          val_d = ValMinus;
        end
      end
      default: ;
    endcase
  end

  assign done_o      = done_q;
  assign res_word0_o = res_q[0*LanesWord +: LanesWord];
  assign res_word1_o = res_q[1*LanesWord +: LanesWord];
  assign res_word2_o = res_q[2*LanesWord +: LanesWord];
  assign res_word3_o = res_q[3*LanesWord +: LanesWord];
  assign flag_o      = flag_q;
  assign overflow_o  = ovf_q;
  assign value_o     = val_q;

endmodule
`default_nettype wire

### sv/mea_lanes.sv
// Per-variable lane operations: difference, sum, max, min and compares.
`default_nettype none
module mea_lanes (
  input  mea_pkg::exp_t  [mea_pkg::NumLanes-1:0] t_i,
  input  mea_pkg::exp_t  [mea_pkg::NumLanes-1:0] s_i,
  output mea_pkg::byte_t [mea_pkg::NumLanes-1:0] diff_o,
  output mea_pkg::byte_t [mea_pkg::NumLanes-1:0] sum_o,
  output mea_pkg::exp_t  [mea_pkg::NumLanes-1:0] max_o,
  output mea_pkg::exp_t  [mea_pkg::NumLanes-1:0] min_o,
  output mea_pkg::lane_cmp_t                     cmp_o
);
  import mea_pkg::*;

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      diff_o[i]        = {1'b0, t_i[i]} - {1'b0, s_i[i]};
      sum_o[i]         = {1'b0, t_i[i]} + {1'b0, s_i[i]};
      cmp_o.t_gt_s[i]  = t_i[i] > s_i[i];
      cmp_o.t_lt_s[i]  = t_i[i] < s_i[i];
      max_o[i]         = cmp_o.t_lt_s[i] ? s_i[i] : t_i[i];
      min_o[i]         = cmp_o.t_gt_s[i] ? s_i[i] : t_i[i];
    end
  end

endmodule
`default_nettype wire

### sv/mea_reduce.sv
// Reductions across lanes: flags, total degrees and highest nonzero difference.
`default_nettype none
module mea_reduce (
  input  mea_pkg::exp_t  [mea_pkg::NumLanes-1:0] t_i,
  input  mea_pkg::exp_t  [mea_pkg::NumLanes-1:0] s_i,
  input  mea_pkg::byte_t [mea_pkg::NumLanes-1:0] diff_i,
  input  mea_pkg::byte_t [mea_pkg::NumLanes-1:0] sum_i,
  input  mea_pkg::lane_cmp_t                     cmp_i,
  output mea_pkg::reduce_t                       red_o
);
  import mea_pkg::*;

  logic [WordDegW-1:0] wdeg_t [NumWords];
  logic [WordDegW-1:0] wdeg_s [NumWords];
  logic [NumLanes-1:0] ovf_lane;

  always_comb begin
    for (int k = 0; k < NumWords; k++) begin
      wdeg_t[k] = '0;
      wdeg_s[k] = '0;
      for (int j = 0; j < LanesWord; j++) begin
        wdeg_t[k] = wdeg_t[k] + WordDegW'(t_i[k*LanesWord+j]);
        wdeg_s[k] = wdeg_s[k] + WordDegW'(s_i[k*LanesWord+j]);
      end
    end
  end

  always_comb begin
    red_o.deg_t = '0;
    red_o.deg_s = '0;
    for (int k = 0; k < NumWords; k++) begin
      red_o.deg_t = red_o.deg_t + DegW'(wdeg_t[k]);
      red_o.deg_s = red_o.deg_s + DegW'(wdeg_s[k]);
    end
    red_o.revlex = '0;
    for (int i = 0; i < NumLanes; i++) begin
      ovf_lane[i] = sum_i[i][7];
      if (diff_i[i] != '0) begin
        red_o.revlex = signed'(diff_i[i]);
      end
    end
    red_o.equal   = ~|(cmp_i.t_gt_s | cmp_i.t_lt_s);
    red_o.t_div_s = ~|cmp_i.t_gt_s;
    red_o.s_div_t = ~|cmp_i.t_lt_s;
    red_o.mul_ovf = |ovf_lane;
  end

endmodule
`default_nettype wire

### sv/mea_checker.sv
// Port-level checks for the monomial exponent ALU and the bind that attaches them.
`default_nettype none
module mea_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                start_i,
  input wire logic                busy_o,
  input wire logic [3:0]          command_i,
  input wire logic                done_o,
  input wire logic [63:0]         res_word0_o,
  input wire logic [63:0]         res_word1_o,
  input wire logic [63:0]         res_word2_o,
  input wire logic [63:0]         res_word3_o,
  input wire logic                flag_o,
  input wire logic                overflow_o,
  input wire logic [12:0]         value_o
);
  import mea_pkg::*;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##2 done_o)
    else $error("transaction gave no result two cycles later");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |-> ##2 !done_o)
    else $error("result without transaction");

  a_unused_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && command_i > CmdGrevlex |-> ##2
      (res_word0_o == '0 && res_word1_o == '0 && res_word2_o == '0 &&
       res_word3_o == '0 && !flag_o && !overflow_o && value_o == '0))
    else $error("unused command gave nonzero result");

  a_flag_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (overflow_o || value_o != '0) |-> !flag_o)
    else $error("flag set together with overflow or value");

endmodule

bind monomial_exponent_alu mea_checker u_mea_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .command_i   (command_i),
  .done_o      (done_o),
  .res_word0_o (res_word0_o),
  .res_word1_o (res_word1_o),
  .res_word2_o (res_word2_o),
  .res_word3_o (res_word3_o),
  .flag_o      (flag_o),
  .overflow_o  (overflow_o),
  .value_o     (value_o)
);
`default_nettype wire

### verif/tb_monomial_exponent_alu.sv
`timescale 1ns / 1ps
// Self-checking testbench for monomial_exponent_alu: directed and random commands over rank settings.
module tb_monomial_exponent_alu;
  import mea_pkg::*;

  localparam logic [3:0] CmdUnusedLo = 4'd9;
  localparam logic [3:0] CmdUnusedHi = 4'd15;
  localparam int         DrainCycles = 3;

  typedef logic [NumLanes*8-1:0] mono_t;

  typedef struct packed {
    mono_t                  words;
    logic                   flag;
    logic                   ovf;
    logic signed [ValW-1:0] val;
  } alu_res_t;

  class alu_scoreboard;
    alu_res_t         expected_q[$];
    logic [RankW-1:0] rank = 6'd32;
    int               mismatches = 0;

    function alu_res_t predict(logic [3:0] cmd, mono_t t, mono_t s);
      alu_res_t   r;
      int         n, dt, ds, diff, sum, v;
      logic [6:0] te [NumLanes];
      logic [6:0] se [NumLanes];
      r    = '0;
      n    = (rank > NumLanes) ? NumLanes : int'(rank);
      dt   = 0;
      ds   = 0;
      diff = 0;
      v    = 0;
      for (int i = 0; i < NumLanes; i++) begin
        te[i] = (i < n) ? t[8*i +: 7] : '0;
        se[i] = (i < n) ? s[8*i +: 7] : '0;
        dt += int'(te[i]);
        ds += int'(se[i]);
      end
      for (int i = NumLanes - 1; i >= 0 && diff == 0; i--) diff = int'(te[i]) - int'(se[i]);
      case (cmd)
        CmdEquals: begin
          r.flag = 1'b1;
          for (int i = 0; i < NumLanes; i++) if (te[i] != se[i]) r.flag = 1'b0;
        end
        CmdDivides: begin
          r.flag = 1'b1;
          for (int i = 0; i < NumLanes; i++) if (te[i] > se[i]) r.flag = 1'b0;
        end
        CmdDivide: begin
          r.flag = 1'b1;
          for (int i = 0; i < NumLanes; i++) if (te[i] < se[i]) r.flag = 1'b0;
          if (r.flag)
            for (int i = 0; i < NumLanes; i++)
              r.words[8*i +: 8] = {1'b0, te[i]} - {1'b0, se[i]};
        end
        CmdMultiply: begin
          for (int i = 0; i < NumLanes; i++) begin
            sum = int'(te[i]) + int'(se[i]);
            if (sum > 127) r.ovf = 1'b1;
            r.words[8*i +: 8] = sum[7:0];
          end
        end
        CmdLcm:
          for (int i = 0; i < NumLanes; i++)
            r.words[8*i +: 8] = {1'b0, (te[i] >= se[i]) ? te[i] : se[i]};
        CmdGcd:
          for (int i = 0; i < NumLanes; i++)
            r.words[8*i +: 8] = {1'b0, (te[i] <= se[i]) ? te[i] : se[i]};
        CmdDegree: v = dt;
        CmdRevlex: v = diff;
        CmdGrevlex: begin
          if (dt > ds) v = 1;
          else if (dt < ds) v = -1;
          else v = (diff < 0) ? 1 : ((diff > 0) ? -1 : 0);
        end
        default: ;
      endcase
      r.val = v[ValW-1:0];
      return r;
    endfunction

    function void note_command(logic [3:0] cmd, mono_t t, mono_t s);
      expected_q.push_back(predict(cmd, t, s));
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch %s: expected %h actual %h", name, want, got);
      end
    endfunction

    function void check_result(alu_res_t got);
      alu_res_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with no transaction outstanding: %h", got);
        return;
      end
      want = expected_q.pop_front();
      for (int k = 0; k < NumWords; k++)
        compare_field($sformatf("res_word%0d", k), want.words[64*k +: 64], got.words[64*k +: 64]);
      compare_field("flag", 64'(want.flag), 64'(got.flag));
      compare_field("overflow", 64'(want.ovf), 64'(got.ovf));
      compare_field("value", 64'(want.val), 64'(got.val));
    endfunction

    function bit failed();
      return mismatches != 0 || expected_q.size() != 0;
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   start_i;
  logic                   busy_o;
  logic                   cfg_we_i;
  logic [RankW-1:0]       cfg_wdata_i;
  logic [3:0]             command_i;
  mono_t                  t_mono;
  mono_t                  s_mono;
  logic                   done_o;
  logic [63:0]            res_word0_o, res_word1_o, res_word2_o, res_word3_o;
  logic                   flag_o;
  logic                   overflow_o;
  logic signed [ValW-1:0] value_o;

  alu_scoreboard scb = new();

  monomial_exponent_alu i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .command_i   (command_i),
    .t_word0_i   (t_mono[63:0]),
    .t_word1_i   (t_mono[127:64]),
    .t_word2_i   (t_mono[191:128]),
    .t_word3_i   (t_mono[255:192]),
    .s_word0_i   (s_mono[63:0]),
    .s_word1_i   (s_mono[127:64]),
    .s_word2_i   (s_mono[191:128]),
    .s_word3_i   (s_mono[255:192]),
    .done_o      (done_o),
    .res_word0_o (res_word0_o),
    .res_word1_o (res_word1_o),
    .res_word2_o (res_word2_o),
    .res_word3_o (res_word3_o),
    .flag_o      (flag_o),
    .overflow_o  (overflow_o),
    .value_o     (value_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) scb.note_command(command_i, t_mono, s_mono);
      if (done_o)
        scb.check_result({res_word3_o, res_word2_o, res_word1_o, res_word0_o,
                          flag_o, overflow_o, value_o});
    end
  end

  function automatic mono_t rand_mono();
    mono_t m;
    for (int k = 0; k < NumLanes / 4; k++) m[32*k +: 32] = $urandom;
    return m;
  endfunction

  // Pairs shaped so that equality, divisibility, equal degree and no-overflow cases show up often.
  function automatic void make_pair(output mono_t t, output mono_t s);
    int         mode, a, b;
    logic [6:0] lo;
    t    = rand_mono();
    s    = rand_mono();
    mode = $urandom_range(0, 7);
    case (mode)
      1: begin
        s = t;
        for (int i = 0; i < NumLanes; i++) s[8*i+7] = 1'($urandom_range(0, 1));
      end
      2: begin
        s = t;
        a = $urandom_range(0, NumLanes - 1);
        s[8*a +: 8] = 8'($urandom);
      end
      3: for (int i = 0; i < NumLanes; i++) begin
        lo = t[8*i +: 7];
        s[8*i +: 8] = {1'($urandom_range(0, 1)), 7'($urandom_range(0, lo))};
      end
      4: for (int i = 0; i < NumLanes; i++) begin
        lo = t[8*i +: 7];
        s[8*i +: 8] = {1'($urandom_range(0, 1)), 7'($urandom_range(lo, 127))};
      end
      5: begin
        s = t;
        a = $urandom_range(0, NumLanes - 1);
        b = $urandom_range(0, NumLanes - 1);
        s[8*a +: 8] = t[8*b +: 8];
        s[8*b +: 8] = t[8*a +: 8];
      end
      6: begin
        t &= {NumLanes{8'hBF}};
        s &= {NumLanes{8'hBF}};
      end
      7: case ($urandom_range(0, 3))
        0: t = '0;
        1: t = {NumLanes{8'h7F}};
        2: s = '0;
        default: s = {NumLanes{8'hFF}};
      endcase
      default: ;
    endcase
  endfunction

  task automatic issue(input logic [3:0] cmd, input mono_t t, input mono_t s);
    start_i   <= 1'b1;
    command_i <= cmd;
    t_mono    <= t;
    s_mono    <= s;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  task automatic idle(input int cycles);
    start_i   <= 1'b0;
    command_i <= 4'($urandom);
    t_mono    <= rand_mono();
    s_mono    <= rand_mono();
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic drain();
    idle(1);
    while (scb.expected_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_rank(input logic [RankW-1:0] r);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= r;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    scb.rank    = r;
  endtask

  task automatic directed_commands();
    mono_t full, all_ff, swap_a, swap_b;
    full   = {NumLanes{8'h7F}};
    all_ff = {NumLanes{8'hFF}};
    swap_a = mono_t'(16'h0002);
    swap_b = mono_t'(16'h0200);
    issue(CmdEquals, full, full);
    issue(CmdEquals, all_ff, full);
    issue(CmdEquals, full, full ^ (mono_t'(1) << 200));
    issue(CmdDivides, '0, full);
    issue(CmdDivides, full, '0);
    issue(CmdDivide, all_ff, full);
    issue(CmdDivide, full, '0);
    issue(CmdDivide, '0, mono_t'(1));
    issue(CmdMultiply, full, all_ff);
    issue(CmdMultiply, {NumLanes{8'h40}}, {NumLanes{8'h3F}});
    issue(CmdLcm, rand_mono(), rand_mono());
    issue(CmdGcd, rand_mono(), rand_mono());
    issue(CmdDegree, all_ff, '0);
    issue(CmdDegree, '0, full);
    issue(CmdRevlex, full, full);
    issue(CmdRevlex, '0, mono_t'(8'h7F) << 248);
    issue(CmdRevlex, mono_t'(8'h7F) << 248, '0);
    issue(CmdRevlex, mono_t'(1), mono_t'(3));
    issue(CmdGrevlex, swap_a, swap_b);
    issue(CmdGrevlex, swap_b, swap_a);
    issue(CmdGrevlex, full, full);
    issue(CmdGrevlex, full, '0);
    issue(CmdUnusedLo, rand_mono(), rand_mono());
    issue(CmdUnusedHi, all_ff, all_ff);
    drain();
  endtask

  task automatic random_commands(input int count);
    int         sent, burst, r;
    logic [3:0] cmd;
    mono_t      t, s;
    sent = 0;
    while (sent < count) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      for (int i = 0; i < burst && sent < count; i++) begin
        r   = $urandom_range(0, 19);
        cmd = (r < 18) ? 4'(r % 9) : 4'($urandom_range(CmdUnusedLo, CmdUnusedHi));
        make_pair(t, s);
        issue(cmd, t, s);
        sent++;
      end
      if ($urandom_range(0, 29) == 0) drain();
      else idle($urandom_range(1, 6));
    end
    drain();
  endtask

  initial begin
    int rank_plan[] = '{1, 0, 63, 33, 16, 31, 7, 32};
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    command_i   = '0;
    t_mono      = '0;
    s_mono      = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    directed_commands();
    random_commands(178);
    foreach (rank_plan[i]) begin
      write_rank(RankW'(rank_plan[i]));
      random_commands(178);
    end
    write_rank(RankW'($urandom_range(1, NumLanes)));
    random_commands(178);
    if (scb.failed()) begin
      $display("CHECK FAILED");
    end else begin
      $display("CHECK OK");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### filelist.f
sv/mea_pkg.sv
sv/mea_lanes.sv
sv/mea_reduce.sv
sv/monomial_exponent_alu.sv
sv/mea_checker.sv
verif/tb_monomial_exponent_alu.sv
